// ===== design/fisp_pkg.sv =====
`timescale 1ns / 1ps

package fisp_pkg;

  // Header bytes of a valid boot image. The third header byte only needs
  // bit 0 clear.
  localparam logic [7:0] HdrByte0 = 8'h43;
  localparam logic [7:0] HdrByte1 = 8'h59;
  localparam logic [7:0] HdrByte3 = 8'hB0;

  localparam int unsigned WordW = 32;
  localparam int unsigned ByteW = 8;

  typedef enum logic [1:0] {
    KindWrite  = 2'd0,
    KindAccept = 2'd1,
    KindReject = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ReasonHeader    = 2'd0,
    ReasonTruncated = 2'd1,
    ReasonChecksum  = 2'd2
  } reason_e;

  typedef struct packed {
    logic [ByteW-1:0] image_byte;
    logic             end_of_image;
  } in_item_t;

  typedef struct packed {
    kind_e            kind;
    logic [WordW-1:0] address;
    logic [WordW-1:0] word_value;
    reason_e          reject_reason;
  } out_item_t;

endpackage

// ===== design/fisp_chan_if.sv =====
`timescale 1ns / 1ps

interface fisp_chan_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== design/fisp_core.sv =====
`timescale 1ns / 1ps

module fisp_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  fisp_pkg::in_item_t  item_i,
  output logic                res_valid_o,
  output fisp_pkg::out_item_t res_o
);

  typedef enum logic [2:0] {
    PhHeader = 3'd0,
    PhCount  = 3'd1,
    PhAddr   = 3'd2,
    PhData   = 3'd3,
    PhCheck  = 3'd4,
    PhDone   = 3'd5
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  slot_q, slot_d;
  logic [23:0] partial_q, partial_d;
  logic [31:0] remain_q, remain_d;
  logic [31:0] addr_q, addr_d;
  logic [31:0] sum_q, sum_d;

  logic [7:0]  b;
  logic        last;
  logic        hdr_ok;
  logic [31:0] word;
  logic        word_done;
  logic        verdict;
  logic        res_valid;
  fisp_pkg::out_item_t res;

  assign b    = item_i.image_byte;
  assign last = item_i.end_of_image;
  assign word = {b, partial_q};

  always_comb begin
    unique case (slot_q)
      2'd0:    hdr_ok = (b == fisp_pkg::HdrByte0);
      2'd1:    hdr_ok = (b == fisp_pkg::HdrByte1);
      2'd2:    hdr_ok = ~b[0];
      default: hdr_ok = (b == fisp_pkg::HdrByte3);
    endcase
  end

  always_comb begin
    phase_d   = phase_q;
    slot_d    = slot_q;
    partial_d = partial_q;
    remain_d  = remain_q;
    addr_d    = addr_q;
    sum_d     = sum_q;
    word_done = 1'b0;
    verdict   = 1'b0;
    res_valid = 1'b0;
    res.kind          = fisp_pkg::KindReject;
    res.address       = '0;
    res.word_value    = '0;
    res.reject_reason = fisp_pkg::ReasonHeader;

    // Byte gathering. Header bytes are checked one at a time; the other
    // active phases assemble little-endian words.
    unique case (phase_q)
      PhHeader: begin
        if (!hdr_ok) begin
          res_valid = 1'b1;
          verdict   = 1'b1;
          phase_d   = PhDone;
        end else if (slot_q == 2'd3) begin
          slot_d  = 2'd0;
          phase_d = PhCount;
        end else begin
          slot_d = slot_q + 2'd1;
        end
      end
      PhCount, PhAddr, PhData, PhCheck: begin
        if (slot_q == 2'd3) begin
          partial_d = '0;
          slot_d    = 2'd0;
          word_done = 1'b1;
        end else begin
          unique case (slot_q)
            2'd0:    partial_d[7:0]   = b;
            2'd1:    partial_d[15:8]  = b;
            default: partial_d[23:16] = b;
          endcase
          slot_d = slot_q + 2'd1;
        end
      end
      default: ;
    endcase

    // A completed word acts according to the phase it belongs to.
    if (word_done) begin
      unique case (phase_q)
        PhCount: begin
          remain_d = word;
          phase_d  = PhAddr;
        end
        PhAddr: begin
          addr_d  = word;
          phase_d = (remain_q == '0) ? PhCheck : PhData;
        end
        PhData: begin
          sum_d             = sum_q + word;
          res_valid         = ~last;
          res.kind          = fisp_pkg::KindWrite;
          res.address       = addr_q;
          res.word_value    = word;
          addr_d            = addr_q + 32'd4;
          remain_d          = remain_q - 32'd1;
          if (remain_q == 32'd1) begin
            phase_d = PhCount;
          end
        end
        default: begin
          res_valid = 1'b1;
          verdict   = 1'b1;
          phase_d   = PhDone;
          if (word == sum_q) begin
            res.kind       = fisp_pkg::KindAccept;
            res.address    = addr_q;
            res.word_value = sum_q;
          end else begin
            res.reject_reason = fisp_pkg::ReasonChecksum;
          end
        end
      endcase
    end

    // The last byte of an image closes it: with no verdict yet the image is
    // truncated, and all state returns to its reset value.
    if (last) begin
      if (!verdict) begin
        if (phase_d != PhDone) begin
          res_valid         = 1'b1;
          res.kind          = fisp_pkg::KindReject;
          res.address       = '0;
          res.word_value    = '0;
          res.reject_reason = fisp_pkg::ReasonTruncated;
        end else begin
          res_valid = 1'b0;
        end
      end
      phase_d   = PhHeader;
      slot_d    = '0;
      partial_d = '0;
      remain_d  = '0;
      addr_d    = '0;
      sum_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PhHeader;
      slot_q    <= '0;
      partial_q <= '0;
      remain_q  <= '0;
      addr_q    <= '0;
      sum_q     <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      slot_q    <= slot_d;
      partial_q <= partial_d;
      remain_q  <= remain_d;
      addr_q    <= addr_d;
      sum_q     <= sum_d;
    end
  end

  assign res_valid_o = res_valid;
  assign res_o       = res;

endmodule

// ===== design/firmware_image_segment_parser.sv =====
`timescale 1ns / 1ps
// Path: an accepted byte waits in the input register until the
// single-pass parser step writes its result into the output register.
// Throughput: one byte per cycle while the output is free or draining.
// Reset: rst_ni is asynchronous and active low; it returns the parser to
// the header phase and empties the input and output registers.

module firmware_image_segment_parser (
  input  logic         clk_i,
  input  logic         rst_ni,
  fisp_chan_if.sink    in_i,
  fisp_chan_if.source  out_o
);

  // Input register. It holds one byte request until the parser step can
  // run, which needs the output register free or draining this cycle.
  logic                valid_q;
  fisp_pkg::in_item_t  item_q;
  logic                advance;

  // Output register holding one result request for the consumer.
  logic                out_valid_q;
  fisp_pkg::out_item_t out_q;

  logic                res_valid;
  fisp_pkg::out_item_t res;

  assign advance    = valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_i.ready) begin
      valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      item_q <= in_i.payload;
    end
  end

  // The parser state advances once per byte; a byte yields at most one
  // result (a word write, an accept or a reject).
  fisp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (advance),
    .item_i      (item_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= res_valid;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && res_valid) begin
      out_q <= res;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

endmodule
